>>> hdl/nrmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC time parser package
// Phase codes, characters, result type and small helper functions.
// ----------------------------------------------------------------------------
package nrmc_pkg;

    localparam int unsigned FIELD_LIMIT_DEF = 16;
    localparam logic [3:0]  ZONE_RESET      = 4'd4;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] HEX_ADJ   = 8'h37;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_HDR_G   = 4'd1,
        PH_HDR_P   = 4'd2,
        PH_HDR_R   = 4'd3,
        PH_HDR_M   = 4'd4,
        PH_HDR_C   = 4'd5,
        PH_HDR_SEP = 4'd6,
        PH_TIME    = 4'd7,
        PH_BODY    = 4'd8,
        PH_SUM_HI  = 4'd9,
        PH_SUM_LO  = 4'd10
    } t_phase;

    // Packed from the lowest bit up: hour, minute, second, minute tens, minute ones.
    typedef struct packed {
        logic [3:0] minute_ones;
        logic [3:0] minute_tens;
        logic [7:0] second_value;
        logic [7:0] minute_value;
        logic [7:0] hour_value;
    } t_result;

    function automatic logic [7:0] f_header_char(input t_phase ph);
        logic [7:0] ch;
        unique case (ph)
            PH_HDR_G: ch = CH_G;
            PH_HDR_P: ch = CH_P;
            PH_HDR_R: ch = CH_R;
            PH_HDR_M: ch = CH_M;
            PH_HDR_C: ch = CH_C;
            default:  ch = CH_COMMA;
        endcase
        return ch;
    endfunction

    function automatic logic [3:0] f_hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        v = (c > CH_NINE) ? (c - HEX_ADJ) : c;
        return v[3:0];
    endfunction

    function automatic logic [7:0] f_times_ten(input logic [3:0] tens, input logic [3:0] ones);
        return {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0} + {4'h0, ones};
    endfunction

    // Returns {tens, ones} of the hour folded to 12-hour form and shifted by the zone.
    function automatic logic [7:0] f_fold_hour(input logic [3:0] tens, input logic [3:0] ones,
                                               input logic [3:0] zone);
        logic [9:0] h;
        logic [9:0] hm;
        logic       gt9;
        h = {2'b00, f_times_ten(tens, ones)};
        if (h > 10'd12) h = h - 10'd12;
        if (h <= {6'd0, zone}) h = h + 10'd12;
        h   = h - {6'd0, zone};
        gt9 = h[9] || (h > 10'd9);
        hm  = h - 10'd10;
        return gt9 ? {4'd1, hm[3:0]} : {4'd0, h[3:0]};
    endfunction

endpackage

>>> hdl/nrmc_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC result register
// Holds one result request until the downstream side takes it.
// ----------------------------------------------------------------------------
module nrmc_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  nrmc_pkg::t_result i_data,
    input  logic             i_flag,
    input  logic             i_tready,
    output logic             o_tvalid,
    output logic [31:0]      o_tdata,
    output logic             o_tuser,
    output logic             o_can_load
);
    import nrmc_pkg::*;

    logic    r_valid;
    t_result r_data;
    logic    r_flag;

    assign o_can_load = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_data <= i_data;
            r_flag <= i_flag;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tuser  = r_flag;

endmodule

>>> hdl/nmea_rmc_time_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC time parser
// Parses "$GPRMC," sentences byte by byte and reports the time with a
// checksum flag at the end of each sentence that carries a checksum.
// ----------------------------------------------------------------------------
// The slave channel takes one received character per request. A result request
// is issued on the master channel after the second checksum digit, in the cycle
// after that byte is accepted; other bytes give no result. The master tdata
// carries hour, minute and second values and the minute digits, and tuser
// carries the checksum match flag.
// One byte is accepted every cycle while s_axis_tready is high; the parse state
// is updated in the same cycle and the result sits in a single output register.
// When the output register holds a result that the receiver has not taken,
// s_axis_tready drops and no byte is accepted until the result leaves.
// The configuration channel writes the zone offset and is always ready.
// Reset sets the zone offset to 4, returns the parser to hunting for the
// start character and clears the digit store and checksum registers.
// ----------------------------------------------------------------------------
module nmea_rmc_time_parser #(
    parameter int unsigned FIELD_LIMIT = nrmc_pkg::FIELD_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] hour_value, [15:8] minute_value,
                                        // [23:16] second_value, [27:24] minute_tens,
                                        // [31:28] minute_ones
    output logic        m_axis_tuser,   // [0] checksum_ok
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data      // [3:0] zone_offset_hours
);
    import nrmc_pkg::*;

    localparam int unsigned OFS_W = $clog2(FIELD_LIMIT + 1);

    t_phase             r_phase, n_phase;
    logic [OFS_W-1:0]   r_ofs, n_ofs;
    logic [3:0]         r_dig [6];
    logic [3:0]         n_dig [6];
    logic [7:0]         r_xor, n_xor;
    logic [7:0]         r_saved, n_saved;
    logic [7:0]         r_sum, n_sum;
    logic [3:0]         r_zone;

    logic       in_fire;
    logic       can_load;
    logic       res_load;
    logic       res_flag;
    t_result    res_data;
    logic [7:0] c;
    logic [7:0] folded;

    assign c             = s_axis_tdata;
    assign s_axis_tready = can_load;
    assign in_fire       = s_axis_tvalid && can_load;
    assign o_cfg_ready   = 1'b1;
    assign folded        = f_fold_hour(r_dig[0], r_dig[1], r_zone);

    always_comb begin
        n_phase = r_phase;
        if (in_fire) begin
            unique case (r_phase)
                PH_HDR_G, PH_HDR_P, PH_HDR_R, PH_HDR_M, PH_HDR_C: begin
                    n_phase = (c == f_header_char(r_phase)) ? t_phase'(r_phase + 4'd1)
                                                             : PH_HUNT;
                end
                PH_HDR_SEP: n_phase = (c == CH_COMMA) ? PH_TIME : PH_HUNT;
                PH_TIME:    n_phase = (c == CH_COMMA) ? PH_BODY : PH_TIME;
                PH_BODY:    n_phase = (c == CH_STAR) ? PH_SUM_HI : PH_BODY;
                PH_SUM_HI:  n_phase = PH_SUM_LO;
                PH_SUM_LO:  n_phase = PH_HUNT;
                default:    n_phase = (c == CH_DOLLAR) ? PH_HDR_G : PH_HUNT;
            endcase
        end
    end

    always_comb begin
        n_ofs    = r_ofs;
        n_dig    = r_dig;
        n_xor    = r_xor;
        n_saved  = r_saved;
        n_sum    = r_sum;
        res_load = 1'b0;
        res_flag = 1'b0;
        res_data = '0;
        if (in_fire) begin
            if (c != CH_STAR) n_xor = r_xor ^ c;
            unique case (r_phase)
                PH_HDR_G, PH_HDR_P, PH_HDR_R, PH_HDR_M, PH_HDR_C: begin
                end
                PH_HDR_SEP: n_ofs = '0;
                PH_TIME: begin
                    if (c == CH_COMMA) begin
                        if (r_ofs > OFS_W'(7)) begin
                            n_dig[0] = folded[7:4];
                            n_dig[1] = folded[3:0];
                        end
                        n_ofs = '0;
                    end else if (r_ofs < OFS_W'(FIELD_LIMIT)) begin
                        if (r_ofs < OFS_W'(6)) n_dig[r_ofs[2:0]] = c[3:0];
                        n_ofs = r_ofs + OFS_W'(1);
                    end
                end
                PH_BODY: begin
                    if (c == CH_STAR) n_saved = r_xor;
                end
                PH_SUM_HI: n_sum = {f_hex_nibble(c), 4'h0};
                PH_SUM_LO: begin
                    n_sum                 = r_sum | {4'h0, f_hex_nibble(c)};
                    res_load              = 1'b1;
                    res_flag              = (r_saved == n_sum);
                    res_data.hour_value   = f_times_ten(r_dig[0], r_dig[1]);
                    res_data.minute_value = f_times_ten(r_dig[2], r_dig[3]);
                    res_data.second_value = f_times_ten(r_dig[4], r_dig[5]);
                    res_data.minute_tens  = r_dig[2];
                    res_data.minute_ones  = r_dig[3];
                    for (int i = 0; i < 6; i++) n_dig[i] = 4'h0;
                end
                default: n_xor = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_ofs   <= '0;
            r_xor   <= '0;
            r_saved <= '0;
            r_sum   <= '0;
            r_zone  <= ZONE_RESET;
            for (int i = 0; i < 6; i++) r_dig[i] <= 4'h0;
        end else begin
            r_phase <= n_phase;
            r_ofs   <= n_ofs;
            r_xor   <= n_xor;
            r_saved <= n_saved;
            r_sum   <= n_sum;
            r_dig   <= n_dig;
            if (i_cfg_valid) r_zone <= i_cfg_data;
        end
    end

    nrmc_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (res_load),
        .i_data     (res_data),
        .i_flag     (res_flag),
        .i_tready   (m_axis_tready),
        .o_tvalid   (m_axis_tvalid),
        .o_tdata    (m_axis_tdata),
        .o_tuser    (m_axis_tuser),
        .o_can_load (can_load)
    );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC time parser testbench
// Streams RMC sentences, broken headers and noise bytes into the parser with
// random gaps and stalls on both sides. A local parser model follows every
// accepted byte, and each result on the master stream is checked against it.
// ----------------------------------------------------------------------------
module tb_top;
    import nrmc_pkg::*;

    localparam int unsigned TIME_FIELD_LIMIT = FIELD_LIMIT_DEF;
    localparam int          CLK_HALF         = 2;
    localparam int          RESET_CYCLES     = 11;
    localparam int          SETTLE_CYCLES    = 4;
    localparam int          IDLE_PERCENT     = 24;
    localparam int          RANDOM_BYTES     = 530;
    localparam int          DRAIN_LIMIT      = 20000;
    localparam int          HOLD_CYCLES      = 300;

    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] LOWER_HEX_ADJ = 8'h57;

    typedef enum int {
        SUM_UPPER,
        SUM_LOWER,
        SUM_WRONG,
        SUM_NONE
    } t_sum_style;

    typedef struct packed {
        logic    sum_match;
        t_result fields;
    } t_rmc_fix;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;    // [7:0] hour, [15:8] minute, [23:16] second,
                                  // [27:24] minute tens, [31:28] minute ones
    logic        m_axis_tuser;    // [0] checksum_ok
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data;      // [3:0] zone_offset_hours

    t_rmc_fix   rmc_fix_q[$];
    logic [7:0] frame_bytes[$];

    t_phase     model_phase;
    logic [4:0] model_offset;
    logic [3:0] model_digits[6];
    logic [7:0] model_xor;
    logic [7:0] model_saved_xor;
    logic [7:0] model_sum;
    logic [3:0] model_zone;

    bit src_idle_en      = 1'b0;
    bit sink_idle_en     = 1'b0;
    int sink_hold_cycles = 0;
    int bytes_sent       = 0;
    int fixes_checked    = 0;
    int mismatch_count   = 0;

    nmea_rmc_time_parser #(
        .FIELD_LIMIT(TIME_FIELD_LIMIT)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        return (c > CH_NINE) ? c[3:0] - 4'd7 : c[3:0];
    endfunction

    function automatic logic [7:0] digit_pair(input logic [3:0] tens, input logic [3:0] ones);
        return tens * 8'd10 + ones;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10) return CH_ZERO + n;
        return (lower ? LOWER_HEX_ADJ : HEX_ADJ) + n;
    endfunction

    task automatic parse_byte(input logic [7:0] c);
        t_rmc_fix    fix;
        int unsigned hour;
        if (c != CH_STAR) model_xor ^= c;
        case (model_phase)
            PH_HDR_G: model_phase = (c == CH_G) ? PH_HDR_P : PH_HUNT;
            PH_HDR_P: model_phase = (c == CH_P) ? PH_HDR_R : PH_HUNT;
            PH_HDR_R: model_phase = (c == CH_R) ? PH_HDR_M : PH_HUNT;
            PH_HDR_M: model_phase = (c == CH_M) ? PH_HDR_C : PH_HUNT;
            PH_HDR_C: model_phase = (c == CH_C) ? PH_HDR_SEP : PH_HUNT;
            PH_HDR_SEP: begin
                model_offset = '0;
                model_phase  = (c == CH_COMMA) ? PH_TIME : PH_HUNT;
            end
            PH_TIME: begin
                if (c == CH_COMMA) begin
                    // A time field of more than seven characters gets the hour folded and shifted.
                    if (model_offset > 5'd7) begin
                        hour = model_digits[0] * 10 + model_digits[1];
                        if (hour > 12) hour -= 12;
                        if (hour <= model_zone) hour += 12;
                        hour -= model_zone;
                        if (hour > 9) begin
                            model_digits[0] = 4'd1;
                            hour -= 10;
                        end else begin
                            model_digits[0] = 4'd0;
                        end
                        model_digits[1] = hour[3:0];
                    end
                    model_offset = '0;
                    model_phase  = PH_BODY;
                end else if (model_offset < TIME_FIELD_LIMIT) begin
                    if (model_offset < 5'd6) model_digits[model_offset[2:0]] = c[3:0];
                    model_offset = model_offset + 5'd1;
                end
            end
            PH_BODY: begin
                if (c == CH_STAR) begin
                    model_saved_xor = model_xor;
                    model_phase     = PH_SUM_HI;
                end
            end
            PH_SUM_HI: begin
                model_sum   = {hex_value(c), 4'h0};
                model_phase = PH_SUM_LO;
            end
            PH_SUM_LO: begin
                model_sum[3:0]           = hex_value(c);
                fix.sum_match            = (model_sum == model_saved_xor);
                fix.fields.hour_value    = digit_pair(model_digits[0], model_digits[1]);
                fix.fields.minute_value  = digit_pair(model_digits[2], model_digits[3]);
                fix.fields.second_value  = digit_pair(model_digits[4], model_digits[5]);
                fix.fields.minute_tens   = model_digits[2];
                fix.fields.minute_ones   = model_digits[3];
                rmc_fix_q.push_back(fix);
                foreach (model_digits[i]) model_digits[i] = '0;
                model_phase = PH_HUNT;
            end
            default: begin
                model_phase = (c == CH_DOLLAR) ? PH_HDR_G : PH_HUNT;
                model_xor   = '0;
            end
        endcase
    endtask

    always @(posedge i_clk) begin : result_check
        t_rmc_fix want;
        t_result  got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata);
            if (rmc_fix_q.size() == 0) begin
                report_mismatch("result with nothing expected", m_axis_tdata, 0);
            end else begin
                want = rmc_fix_q.pop_front();
                if (m_axis_tuser !== want.sum_match)
                    report_mismatch("checksum_ok", m_axis_tuser, want.sum_match);
                if (got.hour_value !== want.fields.hour_value)
                    report_mismatch("hour_value", got.hour_value, want.fields.hour_value);
                if (got.minute_value !== want.fields.minute_value)
                    report_mismatch("minute_value", got.minute_value, want.fields.minute_value);
                if (got.second_value !== want.fields.second_value)
                    report_mismatch("second_value", got.second_value, want.fields.second_value);
                if (got.minute_tens !== want.fields.minute_tens)
                    report_mismatch("minute_tens", got.minute_tens, want.fields.minute_tens);
                if (got.minute_ones !== want.fields.minute_ones)
                    report_mismatch("minute_ones", got.minute_ones, want.fields.minute_ones);
                fixes_checked++;
            end
        end
    end

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                sink_hold_cycles--;
            end else if (sink_idle_en) begin
                m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (src_idle_en && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        parse_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (rmc_fix_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_zone(input logic [3:0] zone);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= zone;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        model_zone = zone;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic frame_text(input string s);
        for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
    endtask

    task automatic frame_time_field();
        int         len;
        bit         tidy;
        logic [7:0] ch;
        tidy = ($urandom_range(0, 99) < 70);
        len  = tidy ? $urandom_range(6, 10) : $urandom_range(0, 20);
        for (int i = 0; i < len; i++) begin
            if (!tidy) ch = 8'($urandom_range(0, 255));
            else if (i == 6) ch = CH_DOT;
            else if ($urandom_range(0, 9) == 0) ch = CH_ZERO + 8'($urandom_range(0, 15));
            else ch = CH_ZERO + 8'($urandom_range(0, 9));
            if (ch == CH_COMMA) ch = CH_ZERO;
            frame_bytes.push_back(ch);
        end
        frame_bytes.push_back(CH_COMMA);
    endtask

    task automatic frame_body(input int max_len);
        logic [7:0] ch;
        repeat ($urandom_range(0, max_len)) begin
            ch = 8'($urandom_range(0, 255));
            if (ch == CH_STAR) ch = CH_COMMA;
            frame_bytes.push_back(ch);
        end
    endtask

    task automatic send_frame(input t_sum_style style);
        logic [7:0] sum;
        sum = '0;
        for (int i = 1; i < frame_bytes.size(); i++) begin
            if (frame_bytes[i] != CH_STAR) sum ^= frame_bytes[i];
        end
        if (style != SUM_NONE) begin
            if (style == SUM_WRONG) sum ^= 8'($urandom_range(1, 255));
            frame_bytes.push_back(CH_STAR);
            frame_bytes.push_back(hex_char(sum[7:4], style == SUM_LOWER));
            frame_bytes.push_back(hex_char(sum[3:0], style == SUM_LOWER));
        end
        foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
        frame_bytes.delete();
    endtask

    task automatic send_rmc(input string time_field, input string rest, input t_sum_style style);
        frame_text("$GPRMC,");
        frame_text(time_field);
        frame_text(",");
        frame_text(rest);
        send_frame(style);
    endtask

    task automatic send_random_sentence();
        frame_text("$GPRMC,");
        frame_time_field();
        frame_body(12);
        send_frame(t_sum_style'($urandom_range(0, 2)));
    endtask

    task automatic test_reset_zone();
        send_rmc("235959.00", "A", SUM_UPPER);
        send_rmc("1234", "V", SUM_UPPER);
    endtask

    task automatic test_header_errors();
        send_rmc("120000.00", "A", SUM_NONE);
        frame_text("$GPRMX,101010.00,A");
        send_frame(SUM_UPPER);
        frame_text("$$GPRMC,101010.00,A");
        send_frame(SUM_UPPER);
    endtask

    task automatic test_time_fields();
        send_rmc("130102.000123456789", "A", SUM_UPPER);
        send_rmc("", "A", SUM_UPPER);
        send_rmc("12*456.78", "", SUM_UPPER);
        send_rmc("000000.00", "A", SUM_UPPER);
        send_rmc("120000.00", "A", SUM_UPPER);
    endtask

    task automatic test_checksum_forms();
        send_rmc("095000.00", "A,4807.038,N", SUM_LOWER);
        send_rmc("095000.00", "A,4807.038,N", SUM_WRONG);
        frame_text("$GPRMC,101010.00,A*zz");
        send_frame(SUM_NONE);
    endtask

    task automatic test_zone_extremes();
        write_zone(4'd0);
        send_rmc("000000.00", "A", SUM_UPPER);
        send_rmc("230000.00", "A", SUM_UPPER);
        write_zone(4'd11);
        send_rmc("110000.00", "A", SUM_UPPER);
        send_rmc("050000.00", "A", SUM_UPPER);
        send_rmc("230000.00", "A", SUM_UPPER);
    endtask

    task automatic test_no_idle();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        repeat (8) send_random_sentence();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    task automatic test_backpressure();
        src_idle_en      = 1'b0;
        sink_hold_cycles = HOLD_CYCLES;
        repeat (3) send_random_sentence();
        src_idle_en = 1'b1;
    endtask

    task automatic test_drain_pause();
        send_random_sentence();
        wait_drained();
        send_random_sentence();
    endtask

    task automatic test_random_traffic();
        int start_bytes;
        int pick;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_random_sentence();
            end else if (pick < 85) begin
                frame_text("$GPRMC,");
                frame_bytes[$urandom_range(1, 6)] = 8'($urandom_range(0, 255));
                frame_time_field();
                frame_body(6);
                send_frame(SUM_UPPER);
            end else if (pick < 95) begin
                repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom_range(0, 255)));
                send_frame(SUM_NONE);
            end else begin
                write_zone(4'($urandom_range(0, 11)));
            end
        end
    endtask

    initial begin
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        i_rst_n         = 1'b0;
        model_phase     = PH_HUNT;
        model_offset    = '0;
        model_xor       = '0;
        model_saved_xor = '0;
        model_sum       = '0;
        model_zone      = ZONE_RESET;
        foreach (model_digits[i]) model_digits[i] = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n      <= 1'b1;
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;

        test_reset_zone();
        test_header_errors();
        test_time_fields();
        test_checksum_forms();
        test_zone_extremes();
        test_no_idle();
        test_backpressure();
        test_drain_pause();
        test_random_traffic();

        s_axis_tvalid <= 1'b0;
        for (int k = 0; k < DRAIN_LIMIT && rmc_fix_q.size() != 0; k++) @(negedge i_clk);
        repeat (2 * SETTLE_CYCLES) @(negedge i_clk);
        if (rmc_fix_q.size() != 0)
            report_mismatch("results never delivered", rmc_fix_q.size(), 0);

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
